// ===== hw/rtl/frame_skip_pacer_macros.svh =====
// Assertion macros shared by the frame skip pacer RTL.
// Depends on nothing; files that check their logic include this header.
`ifndef FRAME_SKIP_PACER_MACROS_SVH
`define FRAME_SKIP_PACER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define FSP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define FSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fsp_pkg.sv =====
// Package of the frame skip pacer: widths, reset values and codes.
// Used by fsp_div and frame_skip_pacer; depends on nothing.
package fsp_pkg;

    localparam int TIME_WIDTH_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int KIND_W      = 2;
    localparam int NOW_W       = 32;
    localparam int FIELD_W     = 16;
    localparam int SKIP_W      = 32;
    localparam int OUT_DATA_W  = 72;
    localparam int CFG_INDEX_W = 2;
    localparam int DIVISOR_W   = 16;

    localparam logic [FIELD_W-1:0] PERIOD_RESET = 16'd60;
    localparam logic [FIELD_W-1:0] WINDOW_RESET = 16'd1000;

    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FRAME   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW = 2'd1;

endpackage

// ===== hw/rtl/frame_skip_pacer.sv =====
// Frame skip pacer top level: request sequencer, pacing state and output register.
// Depends on fsp_pkg, fsp_div and frame_skip_pacer_macros.svh.
// Requests needing no division are answered from the calc state once the output is free.
// A frame with gap above a period, no skips left and debt under a period runs the divider.
// One request at a time; the next is taken only after the previous result is registered.
// Synchronous active-low reset clears all pacing state and loads period 60 and window 1000.
`include "frame_skip_pacer_macros.svh"

module frame_skip_pacer #(
    parameter int TIME_WIDTH  = fsp_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = fsp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fsp_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [fsp_pkg::FIELD_W-1:0]      i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [fsp_pkg::NOW_W-1:0]        s_axis_tdata,  // now_ms
    input  logic [fsp_pkg::KIND_W-1:0]       s_axis_tuser,  // kind
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // draw_frame, sleep_ms, frames_per_window, skips_pending, zero fill
    output logic [fsp_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam int TW = TIME_WIDTH;
    localparam int CW = COUNT_WIDTH;
    localparam int FW = fsp_pkg::FIELD_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TW] ? '1 : s[TW-1:0];
    endfunction

    function automatic logic [fsp_pkg::OUT_DATA_W-1:0] pack_out(
        input logic          draw,
        input logic [FW-1:0] sleep,
        input logic [CW-1:0] frames,
        input logic [TW-1:0] skips
    );
        logic [63:0] f64;
        logic [63:0] s64;
        f64 = 64'(frames);
        s64 = 64'(skips);
        return {7'd0, s64[fsp_pkg::SKIP_W-1:0], f64[FW-1:0], sleep, draw};
    endfunction

    logic [1:0]                  r_state, n_state;
    logic [fsp_pkg::KIND_W-1:0]  r_kind;
    logic [TW-1:0]               r_now;
    logic [FW-1:0]               r_period;
    logic [FW-1:0]               r_window;

    logic [TW-1:0] r_prev,  n_prev;
    logic [TW-1:0] r_dec,   n_dec;
    logic [TW-1:0] r_wend,  n_wend;
    logic [TW-1:0] r_skip,  n_skip;
    logic [TW-1:0] r_debt,  n_debt;
    logic          r_lskip, n_lskip;
    logic [CW-1:0] r_wcnt,  n_wcnt;
    logic [CW-1:0] r_wres,  n_wres;
    logic [TW-1:0] r_carry, n_carry;

    logic                          r_out_valid, n_out_valid;
    logic [fsp_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic [63:0]   w_in64;
    logic [FW-1:0] w_period_eff;
    logic [TW-1:0] w_period_t;
    logic [TW-1:0] w_gap;
    logic [TW-1:0] w_carried;
    logic [TW-1:0] w_elapsed;
    logic [FW-1:0] w_sleep;
    logic          w_need_div;
    logic          w_slot_free;
    logic          w_div_start;
    logic          w_div_done;
    logic [TW-1:0] w_quo;
    logic [FW-1:0] w_rem;

    assign w_in64       = 64'(s_axis_tdata);
    assign w_period_eff = (r_period == '0) ? FW'(1) : r_period;
    assign w_period_t   = TW'(w_period_eff);
    assign w_gap        = r_now - r_prev;
    assign w_carried    = r_lskip ? w_gap : '0;
    assign w_elapsed    = r_now - r_dec;
    assign w_sleep      = (w_elapsed < w_period_t) ? w_period_eff - w_elapsed[FW-1:0] : '0;
    assign w_need_div   = (r_kind == fsp_pkg::KIND_FRAME) && (r_skip == '0)
                        && (r_debt < w_period_t) && (w_gap > w_period_t);
    assign w_slot_free  = !r_out_valid || m_axis_tready;
    assign w_div_start  = (r_state == ST_CALC) && w_need_div;

    fsp_div #(
        .TIME_WIDTH (TW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_gap),
        .i_divisor   (w_period_eff),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    always_comb begin
        logic [TW-1:0] debt_a;
        logic          draw;
        n_state     = r_state;
        n_prev      = r_prev;
        n_dec       = r_dec;
        n_wend      = r_wend;
        n_skip      = r_skip;
        n_debt      = r_debt;
        n_lskip     = r_lskip;
        n_wcnt      = r_wcnt;
        n_wres      = r_wres;
        n_carry     = r_carry;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        debt_a      = r_debt;
        draw        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (w_need_div || w_slot_free) begin
                    if (r_kind == fsp_pkg::KIND_FRAME) begin
                        n_prev  = r_now;
                        n_dec   = r_now;
                        if (r_now > r_wend) begin
                            n_wres = r_wcnt;
                            n_wcnt = CW'(1);
                            n_wend = r_now + TW'(r_window);
                        end else if (r_wcnt != '1) begin
                            n_wcnt = r_wcnt + CW'(1);
                        end
                    end
                    if (w_need_div) begin
                        n_carry = w_carried;
                        n_lskip = 1'b0;
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_IDLE;
                        case (r_kind)
                            fsp_pkg::KIND_RESTART: begin
                                n_prev  = r_now;
                                n_dec   = r_now;
                                n_wend  = r_now;
                                n_skip  = '0;
                                n_debt  = '0;
                                n_lskip = 1'b0;
                                n_wcnt  = '0;
                                n_wres  = '0;
                            end
                            fsp_pkg::KIND_FRAME: begin
                                if (r_skip != '0) begin
                                    n_skip = r_skip - TW'(1);
                                end else if (r_debt >= w_period_t) begin
                                    debt_a = r_debt - w_period_t;
                                end else begin
                                    draw = 1'b1;
                                end
                                n_lskip = !draw;
                                n_debt  = sat_add(debt_a, w_carried);
                            end
                            default: begin
                            end
                        endcase
                        n_out_valid = 1'b1;
                        n_out_data  = pack_out(draw,
                                               (r_kind == fsp_pkg::KIND_QUERY) ? w_sleep : '0,
                                               n_wres, n_skip);
                    end
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_skip  = w_quo - TW'(1);
                    n_debt  = sat_add(r_debt, TW'(w_rem));
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_slot_free) begin
                    n_debt      = sat_add(r_debt, r_carry);
                    n_out_valid = 1'b1;
                    n_out_data  = pack_out(1'b1, '0, r_wres, r_skip);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_period    <= fsp_pkg::PERIOD_RESET;
            r_window    <= fsp_pkg::WINDOW_RESET;
            r_prev      <= '0;
            r_dec       <= '0;
            r_wend      <= '0;
            r_skip      <= '0;
            r_debt      <= '0;
            r_lskip     <= 1'b0;
            r_wcnt      <= '0;
            r_wres      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_dec       <= n_dec;
            r_wend      <= n_wend;
            r_skip      <= n_skip;
            r_debt      <= n_debt;
            r_lskip     <= n_lskip;
            r_wcnt      <= n_wcnt;
            r_wres      <= n_wres;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                if (i_cfg_index == fsp_pkg::REG_PERIOD) begin
                    r_period <= i_cfg_data;
                end else if (i_cfg_index == fsp_pkg::REG_WINDOW) begin
                    r_window <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_kind <= s_axis_tuser;
            r_now  <= w_in64[TW-1:0];
        end
        r_carry    <= n_carry;
        r_out_data <= n_out_data;
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `FSP_ASSERT_SAME(a_done_in_div, i_clk, i_rst_n, w_div_done, r_state == ST_DIV, "Divider result outside the divide step.")
    `FSP_ASSERT_SAME(a_quo_nonzero, i_clk, i_rst_n, w_div_done, w_quo != '0, "Long gap gave a zero quotient.")
    `FSP_ASSERT_NEXT(a_restart_clr, i_clk, i_rst_n, (r_state == ST_CALC) && (r_kind == fsp_pkg::KIND_RESTART) && w_slot_free, (r_skip == '0) && (r_debt == '0), "Restart left pacing state.")

endmodule

// ===== hw/rtl/fsp_div.sv =====
// Iterative restoring divider of the frame skip pacer, one quotient bit a cycle.
// Depends on fsp_pkg and frame_skip_pacer_macros.svh.
`include "frame_skip_pacer_macros.svh"

module fsp_div #(
    parameter int TIME_WIDTH = fsp_pkg::TIME_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [TIME_WIDTH-1:0]          i_dividend,
    input  logic [fsp_pkg::DIVISOR_W-1:0]  i_divisor,
    output logic                           o_done,
    output logic [TIME_WIDTH-1:0]          o_quotient,
    output logic [fsp_pkg::DIVISOR_W-1:0]  o_remainder
);

    localparam int DW    = fsp_pkg::DIVISOR_W;
    localparam int CNT_W = $clog2(TIME_WIDTH + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [TIME_WIDTH-1:0] r_quo;
    logic [DW-1:0]         r_rem;
    logic [DW-1:0]         r_div;

    logic [DW:0] w_rem_sh;
    logic        w_ge;
    logic [DW:0] w_rem_nx;

    assign w_rem_sh = {r_rem, r_quo[TIME_WIDTH-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_div};
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_div}) : w_rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(TIME_WIDTH);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[TIME_WIDTH-2:0], w_ge};
            r_rem <= w_rem_nx[DW-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    `FSP_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start, r_busy, "Divider did not start.")
    `FSP_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, r_done, !r_busy, "Divider done while busy.")
    `FSP_ASSERT_SAME(a_rem_below, i_clk, i_rst_n, r_done, r_rem < r_div, "Remainder not below divisor.")

endmodule

// ===== tb/tb_frame_skip_pacer.sv =====
// Self-checking testbench for frame_skip_pacer: directed and random pacing requests,
// each result checked field by field against a predictor kept in the testbench.
// Depends on fsp_pkg and the frame_skip_pacer RTL; reads no files.
module tb_frame_skip_pacer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [fsp_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int LONG_OP_CYCLES = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AT_RESULT = 600;
    localparam int OPEN_BURST     = 16;

    typedef struct packed {
        logic [fsp_pkg::KIND_W-1:0] kind;
        logic [fsp_pkg::NOW_W-1:0]  now;
    } t_pace_req;

    typedef struct packed {
        logic [fsp_pkg::SKIP_W-1:0]  skips;
        logic [fsp_pkg::FIELD_W-1:0] fpw;
        logic [fsp_pkg::FIELD_W-1:0] sleep;
        logic                        draw;
    } t_pace_res;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [fsp_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [fsp_pkg::FIELD_W-1:0]     i_cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [fsp_pkg::NOW_W-1:0]       s_axis_tdata = '0;
    logic [fsp_pkg::KIND_W-1:0]      s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [fsp_pkg::OUT_DATA_W-1:0]  m_axis_tdata;

    // Predictor state and configuration.
    logic [fsp_pkg::FIELD_W-1:0] cfg_period = fsp_pkg::PERIOD_RESET;
    logic [fsp_pkg::FIELD_W-1:0] cfg_window = fsp_pkg::WINDOW_RESET;
    logic [31:0]        prev_ms = '0;
    logic [31:0]        decided_ms = '0;
    logic [31:0]        window_end_ms = '0;
    logic [31:0]        skips_left = '0;
    logic [31:0]        debt_ms = '0;
    logic               skipped_last = 1'b0;
    logic [15:0]        frames_counted = '0;
    logic [15:0]        frames_reported = '0;

    t_pace_req pending_requests[$];
    t_pace_res expected_results[$];
    t_pace_req next_req;
    t_pace_res got_res;
    t_pace_res want_res;

    logic steady = 1'b0;
    int   mismatches = 0;
    int   results_seen = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    frame_skip_pacer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [31:0] add_saturating(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic t_pace_res pace_request(input t_pace_req req);
        logic [31:0] period;
        logic [31:0] gap;
        logic [31:0] carried;
        logic [31:0] elapsed;
        logic [31:0] left;
        t_pace_res   res;
        res = '0;
        period = (cfg_period == 16'd0) ? 32'd1 : {16'd0, cfg_period};
        case (req.kind)
            fsp_pkg::KIND_RESTART: begin
                prev_ms = req.now;
                decided_ms = req.now;
                window_end_ms = req.now;
                skips_left = '0;
                debt_ms = '0;
                skipped_last = 1'b0;
                frames_counted = '0;
                frames_reported = '0;
            end
            fsp_pkg::KIND_FRAME: begin
                gap = req.now - prev_ms;
                carried = skipped_last ? gap : 32'd0;
                decided_ms = req.now;
                prev_ms = req.now;
                if (req.now > window_end_ms) begin
                    frames_reported = frames_counted;
                    frames_counted = 16'd1;
                    window_end_ms = req.now + {16'd0, cfg_window};
                end else if (frames_counted != 16'hFFFF) begin
                    frames_counted = frames_counted + 16'd1;
                end
                if (skips_left != 32'd0) begin
                    skips_left = skips_left - 32'd1;
                    res.draw = 1'b0;
                end else if (debt_ms >= period) begin
                    debt_ms = debt_ms - period;
                    res.draw = 1'b0;
                end else begin
                    if (gap > period) begin
                        skips_left = gap / period - 32'd1;
                        debt_ms = add_saturating(debt_ms, gap % period);
                    end
                    res.draw = 1'b1;
                end
                skipped_last = !res.draw;
                debt_ms = add_saturating(debt_ms, carried);
            end
            fsp_pkg::KIND_QUERY: begin
                elapsed = req.now - decided_ms;
                left = period - elapsed;
                res.sleep = (elapsed < period) ? left[15:0] : 16'd0;
            end
            default: begin
            end
        endcase
        res.fpw = frames_reported;
        res.skips = skips_left;
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [71:0] got,
                                 input logic [71:0] want);
        $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        mismatches = mismatches + 1;
    endtask

    task automatic push_req(input logic [fsp_pkg::KIND_W-1:0] kind, input logic [31:0] now);
        pending_requests.push_back('{kind: kind, now: now});
    endtask

    function automatic logic [31:0] fresh_origin();
        return ($urandom_range(3) == 0) ? (32'hFFFF_0000 | $urandom_range(16'hFFFF)) : $urandom();
    endfunction

    function automatic logic [31:0] frame_gap(input logic [31:0] p);
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return (p > 32'd2) ? p - 32'd2 + $urandom_range(4) : $urandom_range(4);
        if (sel < 65)
            return $urandom_range(3 * p);
        if (sel < 75)
            return $urandom_range(5);
        if (sel < 90)
            return p * $urandom_range(12) + $urandom_range(p - 32'd1);
        if (sel < 95)
            return $urandom();
        return $urandom_range(32'h3_FFFF);
    endfunction

    task automatic random_run(input int count);
        logic [31:0] p;
        logic [31:0] t;
        int unsigned sel;
        p = (cfg_period == 16'd0) ? 32'd1 : {16'd0, cfg_period};
        t = fresh_origin();
        push_req(fsp_pkg::KIND_RESTART, t);
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if (sel < 3) begin
                t = fresh_origin();
                push_req(fsp_pkg::KIND_RESTART, t);
            end else if (sel < 5) begin
                push_req(KIND_UNUSED, $urandom());
            end else if (sel < 7) begin
                t = $urandom();
                push_req(fsp_pkg::KIND_FRAME, t);
            end else if (sel < 25) begin
                push_req(fsp_pkg::KIND_QUERY, t + $urandom_range(2 * p));
            end else begin
                t = t + frame_gap(p);
                push_req(fsp_pkg::KIND_FRAME, t);
            end
        end
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (LONG_OP_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input logic [15:0] period, input logic [15:0] window);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= fsp_pkg::REG_PERIOD;
        i_cfg_data <= period;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_period = period;
        i_cfg_index <= fsp_pkg::REG_WINDOW;
        i_cfg_data <= window;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_window = window;
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(pace_request('{kind: s_axis_tuser, now: s_axis_tdata}));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 16)) begin
                    next_req = pending_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= next_req.kind;
                    s_axis_tdata <= next_req.now;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    flag_mismatch("result with no request outstanding", m_axis_tdata, '0);
                end else begin
                    got_res = m_axis_tdata[64:0];
                    want_res = expected_results.pop_front();
                    if (got_res.draw !== want_res.draw)
                        flag_mismatch("draw_frame", 72'(got_res.draw), 72'(want_res.draw));
                    if (got_res.sleep !== want_res.sleep)
                        flag_mismatch("sleep_ms", 72'(got_res.sleep), 72'(want_res.sleep));
                    if (got_res.fpw !== want_res.fpw)
                        flag_mismatch("frames_per_window", 72'(got_res.fpw), 72'(want_res.fpw));
                    if (got_res.skips !== want_res.skips)
                        flag_mismatch("skips_pending", 72'(got_res.skips), 72'(want_res.skips));
                    if (m_axis_tdata[71:65] !== 7'd0)
                        flag_mismatch("zero fill", 72'(m_axis_tdata[71:65]), '0);
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady || ($urandom_range(99) >= 16);
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_req(fsp_pkg::KIND_QUERY, 32'd0);
        push_req(KIND_UNUSED, 32'hFFFF_FFFF);
        push_req(fsp_pkg::KIND_FRAME, 32'd30);
        push_req(fsp_pkg::KIND_FRAME, 32'd90);
        push_req(fsp_pkg::KIND_FRAME, 32'd300);
        push_req(fsp_pkg::KIND_FRAME, 32'd310);
        push_req(fsp_pkg::KIND_FRAME, 32'd320);
        push_req(fsp_pkg::KIND_FRAME, 32'd330);
        push_req(fsp_pkg::KIND_QUERY, 32'd330);
        push_req(fsp_pkg::KIND_QUERY, 32'd500);
        push_req(fsp_pkg::KIND_FRAME, 32'd1400);
        // The timestamp wraps between the restart and the frame.
        push_req(fsp_pkg::KIND_RESTART, 32'hFFFF_FFF0);
        push_req(fsp_pkg::KIND_FRAME, 32'h0000_0020);
        push_req(fsp_pkg::KIND_QUERY, 32'h0000_0010);
        // Two huge gaps after skipped frames drive the debt into saturation.
        push_req(fsp_pkg::KIND_RESTART, 32'd0);
        push_req(fsp_pkg::KIND_FRAME, 32'hFFFF_FF00);
        push_req(fsp_pkg::KIND_FRAME, 32'hFFFF_FF00);
        push_req(fsp_pkg::KIND_FRAME, 32'h7FFF_FF00);
        push_req(fsp_pkg::KIND_FRAME, 32'hFFFF_FF00);
        push_req(fsp_pkg::KIND_FRAME, 32'hFFFF_FF00);
        push_req(KIND_UNUSED, 32'hA5A5_5A5A);
        push_req(fsp_pkg::KIND_RESTART, 32'hFFFF_FFFF);
        push_req(fsp_pkg::KIND_QUERY, 32'hFFFF_FFFF);
        drain();

        configure(16'd0, 16'd0);
        push_req(fsp_pkg::KIND_RESTART, 32'd100);
        push_req(fsp_pkg::KIND_FRAME, 32'd100);
        push_req(fsp_pkg::KIND_FRAME, 32'd105);
        push_req(fsp_pkg::KIND_QUERY, 32'd105);
        random_run(100);
        drain();

        configure(16'd1, 16'd1);
        random_run(250);
        drain();

        configure(16'hFFFF, 16'hFFFF);
        random_run(250);
        drain();

        configure(fsp_pkg::PERIOD_RESET, fsp_pkg::WINDOW_RESET);
        random_run(300);
        drain();

        configure(16'($urandom_range(200, 1)), 16'($urandom_range(16'hFFFF)));
        random_run(150);
        drain();

        configure(16'($urandom()), 16'($urandom()));
        random_run(150);
        drain();

        // At the top of the time range the window stays open until the last frame.
        configure(fsp_pkg::PERIOD_RESET, fsp_pkg::WINDOW_RESET);
        steady = 1'b1;
        push_req(fsp_pkg::KIND_RESTART, 32'hFFFF_FFFE);
        repeat (OPEN_BURST) push_req(fsp_pkg::KIND_FRAME, 32'hFFFF_FFFE);
        push_req(fsp_pkg::KIND_FRAME, 32'hFFFF_FFFF);
        push_req(fsp_pkg::KIND_QUERY, 32'hFFFF_FFFF);
        drain();

        configure(16'd17, 16'd250);
        random_run(200);
        drain();
        steady = 1'b0;

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== frame_skip_pacer.f =====
+incdir+hw/rtl
hw/rtl/fsp_pkg.sv
hw/rtl/fsp_div.sv
hw/rtl/frame_skip_pacer.sv
tb/tb_frame_skip_pacer.sv
